@@ rtl/core/dtcsm_pkg.sv @@
// Package with shared types and constants of the trouble code status manager.
package dtcsm_pkg;
  localparam int NUM_CODES = 16;
  localparam int IDX_W = 4;
  localparam int SNAPSHOT_BITS = 32;
  localparam int CNT_W = 5;

  localparam logic [7:0] ST_TF    = 8'h01;
  localparam logic [7:0] ST_TFTOC = 8'h02;
  localparam logic [7:0] ST_PEND  = 8'h04;
  localparam logic [7:0] ST_CONF  = 8'h08;
  localparam logic [7:0] CNT_MAX  = 8'hFF;

  localparam logic [1:0] PH_NONE  = 2'd0;
  localparam logic [1:0] PH_FIRST = 2'd1;
  localparam logic [1:0] PH_LAST  = 2'd2;
  localparam logic [1:0] PH_DONE  = 2'd3;

  localparam logic [2:0] REQ_TICK      = 3'd0;
  localparam logic [2:0] REQ_CLEAR_ONE = 3'd1;
  localparam logic [2:0] REQ_CLEAR_ALL = 3'd2;
  localparam logic [2:0] REQ_STATUS    = 3'd3;
  localparam logic [2:0] REQ_COUNT     = 3'd4;
  localparam logic [2:0] REQ_SNAP_OFR  = 3'd5;
  localparam logic [2:0] REQ_SNAP_RD   = 3'd6;

  localparam logic [2:0] CFG_FAULT_EN  = 3'd0;
  localparam logic [2:0] CFG_CONFIRM   = 3'd1;
  localparam logic [2:0] CFG_SUPPORTED = 3'd2;
  localparam logic [2:0] CFG_GLOBAL    = 3'd3;
  localparam logic [2:0] CFG_LOCAL     = 3'd4;
  localparam logic [2:0] CFG_INVALID   = 3'd5;

  typedef enum logic [2:0] {
    S_IDLE, S_UPDATE, S_PENDCNT, S_CLEAR, S_SCAN, S_DONE
  } state_t;

  typedef struct packed {
    logic on;
    logic start;
    logic [15:0] fault_enable;
    logic [7:0]  confirm_cycles;
    logic [15:0] faults;
  } tick_ctl_t;

  // Per-entry state that the shared update unit walks.
  typedef struct packed {
    logic [7:0] status;
    logic       pmark;
    logic [7:0] pcount;
    logic [1:0] phase;
    logic       clr;
  } entry_t;
endpackage

@@ rtl/core/dtcsm_update.sv @@
// Shared per-entry update unit: one entry per cycle in each tick pass.
module dtcsm_update (
  input  dtcsm_pkg::state_t    pass,
  input  dtcsm_pkg::tick_ctl_t ctl,
  input  logic [3:0]           idx,
  input  dtcsm_pkg::entry_t    cur,
  output dtcsm_pkg::entry_t    nxt
);
  import dtcsm_pkg::*;

  always_comb begin
    logic [7:0] s;
    nxt = cur;
    s = cur.status;
    unique case (pass)
      S_UPDATE: begin
        if (ctl.on && ctl.fault_enable[idx]) begin
          if (ctl.faults[idx]) s = s | ST_TF;
          else s = s & ~ST_TF;
        end
        if (ctl.on && (s & ST_TF) != 8'd0) s = s | ST_TFTOC;
        if (ctl.on) begin
          if (cur.clr) begin
            s = s & ~ST_PEND;
            nxt.pmark = 1'b0;
          end
        end else if ((s & ST_TFTOC) != 8'd0) begin
          s = s | ST_PEND;
          nxt.pmark = 1'b0;
        end else if (cur.pmark) begin
          s = s & ~ST_PEND;
        end else begin
          nxt.pmark = 1'b1;
        end
        if (ctl.on) begin
          if ((s & ST_CONF) != 8'd0) begin
            if ((s & ST_TF) != 8'd0) nxt.phase = PH_LAST;
            else if (cur.clr) s = s & ~ST_CONF;
          end else if ((s & ST_TF) != 8'd0 && (s & ST_PEND) != 8'd0 &&
                       cur.pcount >= ctl.confirm_cycles && !cur.clr) begin
            s = s | ST_CONF;
            nxt.phase = PH_FIRST;
          end
        end
        nxt.status = s;
      end
      S_PENDCNT: begin
        if (ctl.start && (s & ST_PEND) != 8'd0 && cur.pcount != CNT_MAX)
          nxt.pcount = cur.pcount + 8'd1;
      end
      S_CLEAR: begin
        if (cur.clr) begin
          nxt.clr = 1'b0;
          nxt.status = 8'd0;
          nxt.pmark = 1'b0;
        end
      end
      default: ;
    endcase
  end
endmodule

@@ rtl/core/dtc_status_manager.sv @@
// Top level of the diagnostic trouble code status manager.
// Usage: pulse start with a request word on the input ports while busy is low.
// The block raises busy and sequences the request; the result appears on the
// result ports for one cycle with done high. The receiver cannot stall.
// A tick takes 3 passes over the 16 entries through the shared update unit
// (update, pending count, clear) and then the confirmed-count scan. Every
// other request takes the scan only. The entries are walked one at a time
// through the one shared update unit. A new request is accepted the cycle
// after done.
// Configuration writes on cfg_valid/cfg_ready are always ready; the user makes
// them only while the block is idle, which the block itself does not enforce.
// Reset clears the table and counters, sets registers to their defaults,
// the cycle switch to on and the cycle status to off. Snapshot words reset
// to zero with their record numbers.
module dtc_status_manager (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  req_type,
  input  logic [3:0]  dtc_index,
  input  logic        cycle_switch,
  input  logic [15:0] fault_vector,
  input  logic [7:0]  status_mask,
  input  logic [7:0]  record_select,
  input  logic [31:0] snapshot_in,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output logic        done,
  output logic [7:0]  status_out,
  output logic [4:0]  match_count,
  output logic [4:0]  confirmed_count,
  output logic        snapshot_valid,
  output logic [31:0] snapshot_out,
  output logic [7:0]  record_out,
  output logic        cycle_active
);
  import dtcsm_pkg::*;

  logic [15:0] fault_enable;
  logic [7:0]  confirm_cycles, supported_mask, global_record_no;
  logic [7:0]  local_record_no, invalid_record_no;

  entry_t      ent [NUM_CODES];
  logic [31:0] first_data [NUM_CODES];
  logic [7:0]  first_rec  [NUM_CODES];
  logic [31:0] last_data  [NUM_CODES];
  logic [7:0]  last_rec   [NUM_CODES];
  logic        cycle_switch_reg, cycle_status_reg;

  state_t      state, state_next;
  logic [3:0]  idx;
  logic [2:0]  req;
  logic [3:0]  rq_idx;
  logic [15:0] faults;
  logic [7:0]  mask;
  logic [7:0]  sel;
  logic        start_flag;
  logic [4:0]  mcnt, ccnt;

  tick_ctl_t   ctl;
  entry_t      upd;
  logic        last;
  logic        accept;

  assign accept = start && !busy;
  assign cfg_ready = 1'b1;
  assign last = (idx == 4'(NUM_CODES - 1));

  assign ctl.on = cycle_status_reg;
  assign ctl.start = start_flag;
  assign ctl.fault_enable = fault_enable;
  assign ctl.confirm_cycles = confirm_cycles;
  assign ctl.faults = faults;

  dtcsm_update u_upd (
    .pass(state), .ctl(ctl), .idx(idx), .cur(ent[idx]), .nxt(upd)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:    if (accept) state_next = (req_type == REQ_TICK) ? S_UPDATE : S_SCAN;
      S_UPDATE:  if (last) state_next = S_PENDCNT;
      S_PENDCNT: if (last) state_next = S_CLEAR;
      S_CLEAR:   if (last) state_next = S_SCAN;
      S_SCAN:    if (last) state_next = S_DONE;
      S_DONE:    state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_comb begin
    busy = (state != S_IDLE);
    done = (state == S_DONE);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fault_enable <= 16'hFFFF;
      confirm_cycles <= 8'd1;
      supported_mask <= 8'd15;
      global_record_no <= 8'd1;
      local_record_no <= 8'd2;
      invalid_record_no <= 8'hFF;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_FAULT_EN:  fault_enable <= cfg_data;
        CFG_CONFIRM:   confirm_cycles <= cfg_data[7:0];
        CFG_SUPPORTED: supported_mask <= cfg_data[7:0];
        CFG_GLOBAL:    global_record_no <= cfg_data[7:0];
        CFG_LOCAL:     local_record_no <= cfg_data[7:0];
        CFG_INVALID:   invalid_record_no <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CODES; i++) begin
        ent[i] <= '0;
        first_data[i] <= '0;
        first_rec[i] <= '0;
        last_data[i] <= '0;
        last_rec[i] <= '0;
      end
      cycle_switch_reg <= 1'b1;
      cycle_status_reg <= 1'b0;
      idx <= '0;
      start_flag <= 1'b0;
      mcnt <= '0;
      ccnt <= '0;
      req <= REQ_TICK;
      rq_idx <= '0;
      faults <= '0;
      mask <= '0;
      sel <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          idx <= '0;
          mcnt <= '0;
          ccnt <= '0;
          if (accept) begin
            req <= req_type;
            rq_idx <= dtc_index;
            faults <= fault_vector;
            mask <= (status_mask > supported_mask) ? supported_mask : status_mask;
            sel <= record_select;
            unique case (req_type)
              REQ_TICK: begin
                cycle_switch_reg <= cycle_switch;
                start_flag <= cycle_switch && !cycle_status_reg;
              end
              REQ_CLEAR_ONE: ent[dtc_index].clr <= 1'b1;
              REQ_CLEAR_ALL:
                for (int i = 0; i < NUM_CODES; i++) ent[i].clr <= 1'b1;
              REQ_SNAP_OFR:
                if ((ent[dtc_index].status & ST_TF) != 8'd0) begin
                  if (ent[dtc_index].phase == PH_FIRST) begin
                    first_data[dtc_index] <= snapshot_in;
                    first_rec[dtc_index] <= global_record_no;
                    ent[dtc_index].phase <= PH_DONE;
                  end else if (ent[dtc_index].phase == PH_LAST) begin
                    last_data[dtc_index] <= snapshot_in;
                    last_rec[dtc_index] <= local_record_no;
                    ent[dtc_index].phase <= PH_DONE;
                  end
                end
              default: ;
            endcase
          end
        end
        S_UPDATE, S_PENDCNT: begin
          ent[idx] <= upd;
          idx <= idx + 4'd1;
        end
        S_CLEAR: begin
          ent[idx] <= upd;
          if (ent[idx].clr) begin
            first_data[idx] <= '0;
            first_rec[idx] <= invalid_record_no;
            last_data[idx] <= '0;
            last_rec[idx] <= '0;
          end
          idx <= idx + 4'd1;
          if (last) cycle_status_reg <= cycle_switch_reg;
        end
        S_SCAN: begin
          if ((ent[idx].status & mask) != 8'd0) mcnt <= mcnt + 5'd1;
          if ((ent[idx].status & ST_CONF) != 8'd0) ccnt <= ccnt + 5'd1;
          idx <= idx + 4'd1;
        end
        default: ;
      endcase
    end
  end

  // Result word, valid while done is high.
  always_comb begin
    status_out = '0;
    match_count = '0;
    snapshot_valid = 1'b0;
    snapshot_out = '0;
    record_out = '0;
    confirmed_count = ccnt;
    cycle_active = cycle_status_reg;
    if (req == REQ_STATUS) status_out = ent[rq_idx].status & supported_mask;
    if (req == REQ_COUNT) match_count = mcnt;
    if (req == REQ_SNAP_RD) begin
      if (sel == global_record_no) begin
        snapshot_valid = (first_rec[rq_idx] == global_record_no);
        snapshot_out = first_data[rq_idx];
        record_out = first_rec[rq_idx];
      end else if (sel == local_record_no) begin
        snapshot_valid = (last_rec[rq_idx] == local_record_no);
        snapshot_out = last_data[rq_idx];
        record_out = last_rec[rq_idx];
      end
    end
  end
endmodule

@@ rtl/core/dtcsm_checker.sv @@
// Port-level checker for the trouble code status manager, bound to the top.
module dtcsm_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       done,
  input logic [4:0] confirmed_count,
  input logic [4:0] match_count
);
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("busy not raised after accept");
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy) else $error("done outside a request");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done && !busy) else $error("done longer than one cycle");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (confirmed_count <= 5'd16 && match_count <= 5'd16))
    else $error("count beyond table size");
endmodule

bind dtc_status_manager dtcsm_checker u_chk (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .confirmed_count(confirmed_count), .match_count(match_count)
);
